FILE: rtl/cls_pkg.sv
package cls_pkg;

    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_CHAR   = 3'd2;
    localparam logic [2:0] OP_SETCUR = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;
    localparam logic [2:0] OP_NUMBER = 3'd5;

    localparam logic [7:0] LCD_FUNC_SET = 8'h38;
    localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_ENTRY    = 8'h06;
    localparam logic [7:0] LCD_ROW0     = 8'h80;
    localparam logic [7:0] LCD_ROW1     = 8'hC0;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    localparam int TOP_DIGIT = 4;

    typedef enum logic [3:0] {
        BS_FUNC_SET,
        BS_DISP_ON,
        BS_CLEAR,
        BS_ENTRY,
        BS_VALUE,
        BS_SETCUR,
        BS_ROW1,
        BS_HOME,
        BS_DIGIT
    } byte_sel_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_INC,
        CUR_SET
    } cur_op_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        logic      rs;
        logic      last;
        byte_sel_t byte_sel;
        cur_op_t   cur_op;
        logic      dig_load;
        logic      dig_step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic setcur_ok;
        logic hits_row;
        logic hits_end;
        logic digit_zero;
        logic k_zero;
    } dp_stat_t;

    // Returns d times ten to the power k, for k up to 4; any larger k is taken as 4.
    function automatic logic [16:0] cls_step(input logic [2:0] k, input logic [3:0] d);
        logic [13:0] pow;
        begin
            unique case (k)
                3'd0:    pow = 14'd1;
                3'd1:    pow = 14'd10;
                3'd2:    pow = 14'd100;
                3'd3:    pow = 14'd1000;
                default: pow = 14'd10000;
            endcase
            return 17'({13'd0, d} * {3'd0, pow});
        end
    endfunction

endpackage

FILE: rtl/cls_ctrl.sv
module cls_ctrl import cls_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic [2:0] op,
    output logic     s_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT0,
        S_INIT1,
        S_INIT2,
        S_INIT3,
        S_CMD,
        S_CLEAR,
        S_SETCUR,
        S_CHAR,
        S_NUM_LOAD,
        S_DIGIT,
        S_ROW1,
        S_HOME
    } state_t;

    state_t state_reg, state_next;
    logic   more_reg, more_next;
    logic   started_reg, started_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            more_reg    <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            more_reg    <= more_next;
            started_reg <= started_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        more_next    = more_reg;
        started_next = started_reg;
        cmd          = '0;
        cmd.byte_sel = BS_VALUE;
        cmd.cur_op   = CUR_HOLD;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    unique case (op)
                        OP_INIT:   state_next = S_INIT0;
                        OP_CMD:    state_next = S_CMD;
                        OP_CHAR:   state_next = S_CHAR;
                        OP_SETCUR: state_next = S_SETCUR;
                        OP_CLEAR:  state_next = S_CLEAR;
                        OP_NUMBER: state_next = S_NUM_LOAD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT0: begin
                cmd.byte_sel = BS_FUNC_SET;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_INIT1;
                end
            end
            S_INIT1: begin
                cmd.byte_sel = BS_DISP_ON;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_INIT2;
                end
            end
            S_INIT2: begin
                cmd.byte_sel = BS_CLEAR;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_INIT3;
                end
            end
            S_INIT3: begin
                cmd.byte_sel = BS_ENTRY;
                cmd.last     = 1'b1;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.cur_op = CUR_ZERO;
                    state_next = S_IDLE;
                end
            end
            S_CMD: begin
                cmd.byte_sel = BS_VALUE;
                cmd.last     = 1'b1;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLEAR: begin
                cmd.byte_sel = BS_CLEAR;
                cmd.last     = 1'b1;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.cur_op = CUR_ZERO;
                    state_next = S_IDLE;
                end
            end
            S_SETCUR: begin
                cmd.byte_sel = BS_SETCUR;
                cmd.last     = 1'b1;
                if (!stat.setcur_ok) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.cur_op = CUR_SET;
                    state_next = S_IDLE;
                end
            end
            S_CHAR: begin
                cmd.byte_sel = BS_VALUE;
                cmd.rs       = 1'b1;
                cmd.last     = !stat.hits_row && !stat.hits_end;
                if (stat.out_free) begin
                    cmd.emit  = 1'b1;
                    cmd.cur_op = CUR_INC;
                    more_next = 1'b0;
                    priority if (stat.hits_row) begin
                        state_next = S_ROW1;
                    end else if (stat.hits_end) begin
                        state_next = S_HOME;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_NUM_LOAD: begin
                cmd.dig_load = 1'b1;
                started_next = 1'b0;
                state_next   = S_DIGIT;
            end
            S_DIGIT: begin
                cmd.byte_sel = BS_DIGIT;
                cmd.rs       = 1'b1;
                cmd.last     = stat.k_zero && !stat.hits_row && !stat.hits_end;
                if (stat.digit_zero && !started_reg && !stat.k_zero) begin
                    cmd.dig_step = 1'b1;
                end else if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.dig_step = 1'b1;
                    cmd.cur_op   = CUR_INC;
                    started_next = 1'b1;
                    more_next    = !stat.k_zero;
                    priority if (stat.hits_row) begin
                        state_next = S_ROW1;
                    end else if (stat.hits_end) begin
                        state_next = S_HOME;
                    end else if (stat.k_zero) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DIGIT;
                    end
                end
            end
            S_ROW1: begin
                cmd.byte_sel = BS_ROW1;
                cmd.last     = !more_reg;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = more_reg ? S_DIGIT : S_IDLE;
                end
            end
            S_HOME: begin
                cmd.byte_sel = BS_HOME;
                cmd.last     = !more_reg;
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = more_reg ? S_DIGIT : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/cls_dp.sv
module cls_dp import cls_pkg::*; #(
    parameter int COLUMNS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] s_tdata,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int CW = $clog2(2 * COLUMNS);

    logic [15:0]   value_reg;
    logic [7:0]    row_reg;
    logic [7:0]    col_reg;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [15:0]   rem_reg;
    logic [2:0]    k_reg;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    logic          out_rs_reg;
    logic          out_last_reg;

    logic [CW:0]   cur_inc;
    logic [3:0]    digit;
    logic [16:0]   sub_val;
    logic [7:0]    byte_val;
    logic [CW-1:0] set_pos;

    assign cur_inc = {1'b0, cursor_reg} + (CW + 1)'(1);

    always_comb begin
        digit   = 4'd0;
        sub_val = '0;
        for (int d = 1; d <= 9; d++) begin
            if ({1'b0, rem_reg} >= cls_step(k_reg, 4'(d))) begin
                digit   = 4'(d);
                sub_val = cls_step(k_reg, 4'(d));
            end
        end
    end

    assign set_pos = (row_reg == 8'd0) ? col_reg[CW-1:0] : col_reg[CW-1:0] + CW'(COLUMNS);

    always_comb begin
        unique case (cmd.byte_sel)
            BS_FUNC_SET: byte_val = LCD_FUNC_SET;
            BS_DISP_ON:  byte_val = LCD_DISP_ON;
            BS_CLEAR:    byte_val = LCD_CLEAR;
            BS_ENTRY:    byte_val = LCD_ENTRY;
            BS_VALUE:    byte_val = value_reg[7:0];
            BS_SETCUR:   byte_val = ((row_reg == 8'd0) ? LCD_ROW0 : LCD_ROW1) + col_reg;
            BS_ROW1:     byte_val = LCD_ROW1;
            BS_HOME:     byte_val = LCD_ROW0;
            BS_DIGIT:    byte_val = ASCII_ZERO + {4'd0, digit};
            default:     byte_val = 8'd0;
        endcase
    end

    always_comb begin
        unique case (cmd.cur_op)
            CUR_HOLD: cursor_next = cursor_reg;
            CUR_ZERO: cursor_next = '0;
            CUR_INC:  cursor_next = (cur_inc == (CW + 1)'(2 * COLUMNS)) ? '0 : cur_inc[CW-1:0];
            CUR_SET:  cursor_next = set_pos;
            default:  cursor_next = cursor_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cursor_reg <= cursor_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_tdata[15:0];
            row_reg   <= s_tdata[23:16];
            col_reg   <= s_tdata[31:24];
        end
        if (cmd.dig_load) begin
            rem_reg <= value_reg;
            k_reg   <= 3'(TOP_DIGIT);
        end else if (cmd.dig_step) begin
            rem_reg <= 16'({1'b0, rem_reg} - sub_val);
            k_reg   <= k_reg - 3'd1;
        end
        if (cmd.emit) begin
            out_data_reg <= byte_val;
            out_rs_reg   <= cmd.rs;
            out_last_reg <= cmd.last;
        end
    end

    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.setcur_ok  = (col_reg < 8'(COLUMNS)) && (row_reg == 8'd0 || row_reg == 8'd1);
    assign stat.hits_row   = (cur_inc == (CW + 1)'(COLUMNS));
    assign stat.hits_end   = (cur_inc == (CW + 1)'(2 * COLUMNS));
    assign stat.digit_zero = (digit == 4'd0);
    assign stat.k_zero     = (k_reg == 3'd0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/char_lcd_write_sequencer.sv
// Turns requests into 8-bit LCD bus writes (command or data) and tracks the cursor over both
// rows. A request is accepted while the sequencer is idle, and each write it causes is issued
// once the output is free; number printing loads the value and then works through the
// five decimal places, skipping leading zeros, one place per cycle while the output is free.
// A new request waits until the previous one has put any last word in the output register.
module char_lcd_write_sequencer import cls_pkg::*; #(
    parameter int COLUMNS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // value[15:0], row[23:16], col[31:24]
    input  logic [2:0]  s_tuser,  // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // bus_data[7:0]
    output logic        m_tuser,  // reg_select[0]
    output logic        m_tlast
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    cls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    cls_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |-> dp_stat.out_free)
        else $error("write issued while the output word is still held");

    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.dig_step || dp_cmd.dig_load) |-> !s_tready)
        else $error("digit unit active while requests are accepted");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.emit |=> m_tvalid)
        else $error("issued write does not appear on the output");

endmodule

FILE: dv/tb.sv
module tb;
    import cls_pkg::*;

    localparam int LCD_COLUMNS = 16;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT_REQ = 150;
    localparam int LONG_HOLD = 150;
    localparam int CALM_TAIL = 50;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] value;
        logic [7:0]  row;
        logic [7:0]  col;
        bit          drain;
    } lcd_req_t;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       is_last;
    } lcd_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // value[15:0], row[23:16], col[31:24]
    logic [2:0]  s_tuser = '0;   // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // bus_data[7:0]
    logic        m_tuser;        // reg_select[0]
    logic        m_tlast;

    lcd_req_t   pending_reqs[$];
    lcd_write_t lcd_writes_due[$];
    lcd_write_t req_writes[$];
    lcd_req_t   cur_req;
    lcd_write_t got_write;
    int         cursor_pos = 0;
    int         op_seen[8];
    int         total_reqs = 0;
    int         req_accepted = 0;
    int         writes_checked = 0;
    int         fail_cnt = 0;
    int         gap_left = 0;
    int         hold_left = 0;
    bit         long_hold_done = 1'b0;
    int         stall_cycles = 0;

    char_lcd_write_sequencer #(.COLUMNS(LCD_COLUMNS)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit idling_allowed();
        return (req_accepted < total_reqs - CALM_TAIL) && ((req_accepted / 40) % 3 != 2);
    endfunction

    task automatic add_write(input logic rs, input logic [7:0] data);
        lcd_write_t w;
        w.rs = rs;
        w.data = data;
        w.is_last = 1'b0;
        req_writes.push_back(w);
    endtask

    // A data write moves the cursor; reaching the end of a row also moves the display cursor.
    task automatic put_char(input logic [7:0] ch);
        add_write(1'b1, ch);
        cursor_pos++;
        if (cursor_pos == LCD_COLUMNS) begin
            add_write(1'b0, LCD_ROW1);
        end else if (cursor_pos >= 2 * LCD_COLUMNS) begin
            add_write(1'b0, LCD_ROW0);
            cursor_pos = 0;
        end
    endtask

    task automatic predict_lcd_writes(input lcd_req_t r);
        int         v;
        int         cnt;
        int         digits[5];
        logic [7:0] ch;
        lcd_write_t tail;
        req_writes.delete();
        op_seen[r.op]++;
        case (r.op)
            OP_INIT: begin
                add_write(1'b0, LCD_FUNC_SET);
                add_write(1'b0, LCD_DISP_ON);
                add_write(1'b0, LCD_CLEAR);
                add_write(1'b0, LCD_ENTRY);
                cursor_pos = 0;
            end
            OP_CMD: begin
                add_write(1'b0, r.value[7:0]);
            end
            OP_CHAR: begin
                put_char(r.value[7:0]);
            end
            OP_SETCUR: begin
                if (r.col < LCD_COLUMNS && r.row == 8'd0) begin
                    add_write(1'b0, LCD_ROW0 + r.col);
                    cursor_pos = int'(r.col);
                end else if (r.col < LCD_COLUMNS && r.row == 8'd1) begin
                    add_write(1'b0, LCD_ROW1 + r.col);
                    cursor_pos = int'(r.col) + LCD_COLUMNS;
                end
            end
            OP_CLEAR: begin
                add_write(1'b0, LCD_CLEAR);
                cursor_pos = 0;
            end
            OP_NUMBER: begin
                v = int'(r.value);
                cnt = 0;
                if (v == 0) begin
                    put_char(ASCII_ZERO);
                end else begin
                    while (v != 0) begin
                        digits[cnt] = v % 10;
                        v = v / 10;
                        cnt++;
                    end
                    while (cnt > 0) begin
                        cnt--;
                        ch = ASCII_ZERO + 8'(digits[cnt]);
                        put_char(ch);
                    end
                end
            end
            default: begin
            end
        endcase
        if (req_writes.size() != 0) begin
            tail = req_writes.pop_back();
            tail.is_last = 1'b1;
            req_writes.push_back(tail);
        end
        while (req_writes.size() != 0) begin
            lcd_writes_due.push_back(req_writes.pop_front());
        end
    endtask

    task automatic queue_req(input logic [2:0] op, input logic [15:0] value,
                             input logic [7:0] row, input logic [7:0] col, input bit drain);
        lcd_req_t r;
        r.op = op;
        r.value = value;
        r.row = row;
        r.col = col;
        r.drain = drain;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_lcd_writes(cur_req);
                req_accepted++;
                if (idling_allowed() && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 6);
                end
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain && lcd_writes_due.size() != 0)) begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {cur_req.col, cur_req.row, cur_req.value};
                s_tuser <= cur_req.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                writes_checked++;
                if (lcd_writes_due.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected word rs=%0b data=%02h last=%0b", $time,
                             m_tuser, m_tdata, m_tlast);
                end else begin
                    got_write = lcd_writes_due.pop_front();
                    if (got_write.rs !== m_tuser || got_write.data !== m_tdata ||
                        got_write.is_last !== m_tlast) begin
                        fail_cnt++;
                        $display("%0t: expected rs/data/last %0b/%02h/%0b, got %0b/%02h/%0b",
                                 $time, got_write.rs, got_write.data, got_write.is_last,
                                 m_tuser, m_tdata, m_tlast);
                    end
                end
            end
            if (!long_hold_done && req_accepted >= HOLD_AT_REQ) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end else if (hold_left == 0 && idling_allowed() && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(1, 6);
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a handshake.", stall_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int         n_eff;
        int         pick;
        int         k;
        logic [2:0] op;
        logic [15:0] val;
        logic [7:0] row;
        logic [7:0] col;

        queue_req(OP_INIT, 16'($urandom_range(0, 65535)), 8'h00, 8'h00, 1'b0);
        queue_req(OP_CMD, 16'h0000, 8'hFF, 8'hFF, 1'b0);
        queue_req(OP_CMD, 16'hFFFF, 8'h00, 8'h00, 1'b0);
        queue_req(OP_CHAR, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_req(OP_CHAR, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_req(OP_SETCUR, 16'h0000, 8'd0, 8'd0, 1'b0);
        queue_req(OP_SETCUR, 16'hFFFF, 8'd1, 8'd15, 1'b0);
        // The character in the last column of row 1 wraps the cursor home.
        queue_req(OP_CHAR, 16'h0041, 8'd0, 8'd0, 1'b0);
        queue_req(OP_SETCUR, 16'h0000, 8'd0, 8'd15, 1'b0);
        // The character in the last column of row 0 moves on to row 1.
        queue_req(OP_CHAR, 16'h0042, 8'd0, 8'd0, 1'b0);
        queue_req(OP_SETCUR, 16'h0000, 8'd0, 8'd16, 1'b0);
        queue_req(OP_SETCUR, 16'h0000, 8'd2, 8'd0, 1'b0);
        queue_req(OP_SETCUR, 16'h0000, 8'd255, 8'd255, 1'b0);
        queue_req(OP_CLEAR, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_req(OP_NUMBER, 16'd0, 8'h00, 8'h00, 1'b0);
        queue_req(OP_NUMBER, 16'd65535, 8'h00, 8'h00, 1'b0);
        queue_req(OP_NUMBER, 16'd10000, 8'h00, 8'h00, 1'b0);
        queue_req(OP_SETCUR, 16'h0000, 8'd1, 8'd13, 1'b0);
        // Five digits from column 13 of row 1 run past the end of the display.
        queue_req(OP_NUMBER, 16'd65535, 8'h00, 8'h00, 1'b0);
        queue_req(OP_SPARE6, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        queue_req(OP_SPARE7, 16'h0000, 8'h00, 8'h00, 1'b0);
        queue_req(OP_CMD, 16'h00A5, 8'h00, 8'h00, 1'b1);
        queue_req(OP_INIT, 16'h0000, 8'h00, 8'h00, 1'b0);

        n_eff = 0;
        while (n_eff < 447) begin
            val = 16'($urandom_range(0, 65535));
            row = 8'($urandom_range(0, 255));
            col = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                op = OP_CHAR;
            end else if (pick < 55) begin
                op = OP_NUMBER;
                k = $urandom_range(1, 5);
                case (k)
                    1: val = 16'($urandom_range(0, 9));
                    2: val = 16'($urandom_range(10, 99));
                    3: val = 16'($urandom_range(100, 999));
                    4: val = 16'($urandom_range(1000, 9999));
                    default: val = 16'($urandom_range(10000, 65535));
                endcase
            end else if (pick < 72) begin
                op = OP_SETCUR;
                row = 8'($urandom_range(0, 1));
                col = 8'($urandom_range(0, LCD_COLUMNS - 1));
            end else if (pick < 82) begin
                op = OP_CMD;
            end else if (pick < 88) begin
                op = OP_CLEAR;
            end else if (pick < 92) begin
                op = OP_INIT;
            end else if (pick < 96) begin
                op = OP_SETCUR;
            end else begin
                op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
            end
            queue_req(op, val, row, col, n_eff == 250);
            n_eff++;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid) @(posedge aclk);
        while (lcd_writes_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d requests: %0d characters, %0d numbers, %0d cursor moves.",
                 req_accepted, op_seen[OP_CHAR], op_seen[OP_NUMBER], op_seen[OP_SETCUR]);
        $display("Checked %0d bus writes through a long output stall and a drain pause.",
                 writes_checked);
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
